/* rtl/gdt_pkg.sv */
// Shared types and constants of the gcd dependence test unit.
// Used by gdt_datapath, gdt_ctrl and gcd_dependence_test_unit; depends on nothing.
package gdt_pkg;

  localparam int INDEX_WIDTH    = 32;
  localparam int ARRAY_ID_WIDTH = 16;
  localparam int SHIFT_WIDTH    = $clog2(INDEX_WIDTH);

  // flips the sign bit to map two's complement onto an order-preserving unsigned range
  localparam logic [INDEX_WIDTH-1:0] IDX_SIGN = {1'b1, {(INDEX_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [ARRAY_ID_WIDTH-1:0]     first_array_id;
    logic [ARRAY_ID_WIDTH-1:0]     second_array_id;
    logic signed [INDEX_WIDTH-1:0] first_stride;
    logic signed [INDEX_WIDTH-1:0] second_stride;
    logic signed [INDEX_WIDTH-1:0] first_offset;
    logic signed [INDEX_WIDTH-1:0] second_offset;
  } in_item_t;

  typedef struct packed {
    logic                   dependence_possible;
    logic                   distance_valid;
    logic [INDEX_WIDTH-1:0] distance;
    logic [INDEX_WIDTH-1:0] stride_gcd;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic gcd_fin;
    logic mod_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gcd_zero;
    logic need_mod;
    logic mod_last;
  } dp_stat_t;

endpackage

/* rtl/gdt_datapath.sv */
// Datapath of the gcd dependence test: operand registers, binary gcd step,
// bit-serial remainder and result assembly. Depends on gdt_pkg.
module gdt_datapath (
  input  logic               clk,
  input  gdt_pkg::in_item_t  in_data,
  input  gdt_pkg::dp_cmd_t   cmd,
  output gdt_pkg::dp_stat_t  stat,
  output gdt_pkg::out_item_t out_data
);

  logic [gdt_pkg::INDEX_WIDTH-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [gdt_pkg::INDEX_WIDTH-1:0] g_r, g_nxt, diff_r, diff_nxt, rem_r, rem_nxt;
  logic [gdt_pkg::SHIFT_WIDTH-1:0] k_r, k_nxt, cnt_r, cnt_nxt;
  logic                            same_r, same_nxt, match_r, match_nxt;

  logic [gdt_pkg::INDEX_WIDTH-1:0] s1, s2, bp, bq, ab_or;
  logic [gdt_pkg::INDEX_WIDTH:0]   r_sh, g_ext;

  always_comb begin
    s1    = $unsigned(in_data.first_stride);
    s2    = $unsigned(in_data.second_stride);
    bp    = $unsigned(in_data.first_offset) ^ gdt_pkg::IDX_SIGN;
    bq    = $unsigned(in_data.second_offset) ^ gdt_pkg::IDX_SIGN;
    ab_or = a_r | b_r;
    r_sh  = {rem_r, diff_r[cnt_r]};
    g_ext = {1'b0, g_r};

    a_nxt     = a_r;
    b_nxt     = b_r;
    g_nxt     = g_r;
    diff_nxt  = diff_r;
    rem_nxt   = rem_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    same_nxt  = same_r;
    match_nxt = match_r;

    if (cmd.load) begin
      a_nxt     = s1[gdt_pkg::INDEX_WIDTH-1] ? (~s1 + 1'b1) : s1;
      b_nxt     = s2[gdt_pkg::INDEX_WIDTH-1] ? (~s2 + 1'b1) : s2;
      diff_nxt  = (bp >= bq) ? (bp - bq) : (bq - bp);
      k_nxt     = '0;
      same_nxt  = (in_data.first_array_id == in_data.second_array_id);
      match_nxt = (in_data.first_array_id == in_data.second_array_id) && (s1 == s2);
    end else if (cmd.gcd_step) begin
      // strip common factors of two, then subtract odd from odd
      if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end else if (cmd.gcd_fin) begin
      // one operand is zero, the other holds the odd part
      g_nxt   = ab_or << k_r;
      rem_nxt = '0;
      cnt_nxt = gdt_pkg::SHIFT_WIDTH'(gdt_pkg::INDEX_WIDTH - 1);
    end else if (cmd.mod_step) begin
      if (r_sh >= g_ext) begin
        rem_nxt = gdt_pkg::INDEX_WIDTH'(r_sh - g_ext);
      end else begin
        rem_nxt = r_sh[gdt_pkg::INDEX_WIDTH-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    g_r     <= g_nxt;
    diff_r  <= diff_nxt;
    rem_r   <= rem_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    same_r  <= same_nxt;
    match_r <= match_nxt;
  end

  assign stat.gcd_zero = (a_r == '0) || (b_r == '0);
  assign stat.need_mod = same_r && (diff_r != '0) && (ab_or != '0);
  assign stat.mod_last = (cnt_r == '0);

  assign out_data.dependence_possible =
    same_r && ((diff_r == '0) || ((g_r != '0) && (rem_r == '0)));
  assign out_data.distance_valid = match_r;
  assign out_data.distance       = match_r ? diff_r : '0;
  assign out_data.stride_gcd     = g_r;

endmodule

/* rtl/gdt_ctrl.sv */
// Controller of the gcd dependence test: sequences load, gcd and remainder
// phases and raises the result strobe. Depends on gdt_pkg.
module gdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gdt_pkg::dp_stat_t stat,
  output gdt_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_MOD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (stat.gcd_zero) begin
          cmd.gcd_fin = 1'b1;
          if (stat.need_mod) begin
            state_nxt = ST_MOD;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/gcd_dependence_test_unit.sv */
// Top level of the gcd dependence test; joins gdt_ctrl and gdt_datapath.
// Depends on gdt_pkg.
// Operation: from the accepting edge to the result strobe, the binary gcd loop
// (one step a cycle) runs until an operand is zero, then a finishing step, then,
// when a divisibility check is needed, a bit-serial remainder pass over the
// offset difference. One item at a time; a new start is taken in the strobe
// cycle. The receiver cannot stall. Synchronous active-low reset clears the
// controller only; no result is shown until one is computed.
module gcd_dependence_test_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gdt_pkg::in_item_t  in_data,
  output logic               out_valid,
  output gdt_pkg::out_item_t out_data
);

  gdt_pkg::dp_cmd_t  cmd;   // one-hot phase commands toward the datapath
  gdt_pkg::dp_stat_t stat;  // loop-exit conditions back to the controller

  // Sequence the phases: load on transfer, gcd steps until an operand hits zero, then the
  // bit-serial remainder when the arrays match, the offsets differ and a stride is nonzero.
  gdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Hold the operands and result; the output fields stay stable while idle
  // after the strobe until the next transfer loads new operands.
  gdt_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* rtl/gdt_checker.sv */
// Port-level checks of the gcd dependence test unit and the bind that
// attaches them. Depends on gcd_dependence_test_unit.
module gdt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("unit not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not start work");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still working");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

endmodule

bind gcd_dependence_test_unit gdt_checker u_gdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

/* tb/dependence_checker.sv */
// Checker for the gcd dependence test unit: predicts every verdict and compares it.
// Watches the start/busy input handshake and the out_valid strobe; depends on gdt_pkg.
`timescale 1ns / 100ps

module dependence_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  gdt_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  gdt_pkg::out_item_t out_data,
  output int                 pending,
  output int                 mismatch_count
);

  localparam int PRINT_CAP = 40;

  gdt_pkg::out_item_t expected_verdicts[$];
  gdt_pkg::out_item_t want;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [gdt_pkg::INDEX_WIDTH-1:0] stride_magnitude(
      input logic [gdt_pkg::INDEX_WIDTH-1:0] v);
    // two's complement negate; the most negative value maps onto itself
    return v[gdt_pkg::INDEX_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [gdt_pkg::INDEX_WIDTH-1:0] euclid_gcd(
      input logic [gdt_pkg::INDEX_WIDTH-1:0] a,
      input logic [gdt_pkg::INDEX_WIDTH-1:0] b);
    logic [gdt_pkg::INDEX_WIDTH-1:0] x;
    logic [gdt_pkg::INDEX_WIDTH-1:0] y;
    logic [gdt_pkg::INDEX_WIDTH-1:0] r;
    x = a;
    y = b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic gdt_pkg::out_item_t predict_dependence(input gdt_pkg::in_item_t item);
    logic                            same_array;
    logic [gdt_pkg::INDEX_WIDTH-1:0] g;
    logic [gdt_pkg::INDEX_WIDTH-1:0] bp;
    logic [gdt_pkg::INDEX_WIDTH-1:0] bq;
    logic [gdt_pkg::INDEX_WIDTH-1:0] diff;
    gdt_pkg::out_item_t              r;
    same_array = (item.first_array_id == item.second_array_id);
    g  = euclid_gcd(stride_magnitude(item.first_stride),
                    stride_magnitude(item.second_stride));
    // bias the offsets so an unsigned compare orders them as signed values
    bp = item.first_offset ^ gdt_pkg::IDX_SIGN;
    bq = item.second_offset ^ gdt_pkg::IDX_SIGN;
    diff = (bp >= bq) ? (bp - bq) : (bq - bp);
    if (!same_array) begin
      r.dependence_possible = 1'b0;
    end else if (diff == '0) begin
      r.dependence_possible = 1'b1;
    end else if (g == '0) begin
      r.dependence_possible = 1'b0;
    end else begin
      r.dependence_possible = ((diff % g) == '0);
    end
    r.distance_valid = same_array && (item.first_stride == item.second_stride);
    r.distance       = r.distance_valid ? diff : '0;
    r.stride_gcd     = g;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // retire the result first: a new transfer may be taken in the strobe cycle
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with no transfer outstanding: %h", out_data));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.dependence_possible !== want.dependence_possible) begin
            report_mismatch($sformatf("dependence_possible got %b expected %b",
                                      out_data.dependence_possible, want.dependence_possible));
          end
          if (out_data.distance_valid !== want.distance_valid) begin
            report_mismatch($sformatf("distance_valid got %b expected %b",
                                      out_data.distance_valid, want.distance_valid));
          end
          if (out_data.distance !== want.distance) begin
            report_mismatch($sformatf("distance got %h expected %h",
                                      out_data.distance, want.distance));
          end
          if (out_data.stride_gcd !== want.stride_gcd) begin
            report_mismatch($sformatf("stride_gcd got %h expected %h",
                                      out_data.stride_gcd, want.stride_gcd));
          end
        end
      end
      if (start && !busy) begin
        expected_verdicts.push_back(predict_dependence(in_data));
      end
    end
    pending <= expected_verdicts.size();
  end

endmodule

/* tb/gcd_dependence_test_unit_tb.sv */
// Top of the gcd dependence test unit testbench: clock, reset, stimulus and verdict.
// Instantiates gcd_dependence_test_unit and dependence_checker; depends on gdt_pkg.
`timescale 1ns / 100ps

module gcd_dependence_test_unit_tb;

  localparam int ITEM_COUNT    = 1750;
  localparam int DIRECTED_HINT = 22;
  localparam int PHASE_ITEMS   = (ITEM_COUNT - DIRECTED_HINT) / 3;
  // gcd loop, finishing step and remainder pass, plus margin
  localparam int WORST_LATENCY = 3 * gdt_pkg::INDEX_WIDTH + 2;
  localparam int LONG_GAP      = WORST_LATENCY + 8;
  localparam longint RUN_LIMIT_NS = 3_000_000;

  localparam logic [gdt_pkg::INDEX_WIDTH-1:0] IDX_MIN = gdt_pkg::IDX_SIGN;
  localparam logic [gdt_pkg::INDEX_WIDTH-1:0] IDX_MAX = ~gdt_pkg::IDX_SIGN;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  gdt_pkg::in_item_t  in_data;
  logic               out_valid;
  gdt_pkg::out_item_t out_data;
  int                 pending;
  int                 mismatches;
  int                 idle_pct;

  gcd_dependence_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  dependence_checker verdict_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .pending        (pending),
    .mismatch_count (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Idle the sender after a transfer. Long gaps reach into every phase of the
  // next computation; scramble the payload while start is low so stray data
  // on an idle cycle would be caught.
  task automatic sender_gap();
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, LONG_GAP);
      start   <= 1'b0;
      in_data <= gdt_pkg::in_item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom()});
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one item and hold it until the block takes it (start high, busy low).
  task automatic send_transfer(input gdt_pkg::in_item_t item);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    sender_gap();
  endtask

  // Drop start and hold off until every outstanding verdict has been checked.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic gdt_pkg::in_item_t make_pair(
      input logic [gdt_pkg::ARRAY_ID_WIDTH-1:0] id1,
      input logic [gdt_pkg::ARRAY_ID_WIDTH-1:0] id2,
      input logic [gdt_pkg::INDEX_WIDTH-1:0]    s1,
      input logic [gdt_pkg::INDEX_WIDTH-1:0]    s2,
      input logic [gdt_pkg::INDEX_WIDTH-1:0]    o1,
      input logic [gdt_pkg::INDEX_WIDTH-1:0]    o2);
    gdt_pkg::in_item_t item;
    item.first_array_id  = id1;
    item.second_array_id = id2;
    item.first_stride    = s1;
    item.second_stride   = s2;
    item.first_offset    = o1;
    item.second_offset   = o2;
    return item;
  endfunction

  // Mix small values (interesting gcds), extremes, shifted values and full noise.
  function automatic logic [gdt_pkg::INDEX_WIDTH-1:0] random_index();
    logic [gdt_pkg::INDEX_WIDTH-1:0] v;
    case ($urandom_range(5))
      0: v = int'($urandom_range(80)) - 40;
      1: begin
        case ($urandom_range(5))
          0: v = '0;
          1: v = 1;
          2: v = '1;
          3: v = IDX_MIN;
          4: v = IDX_MAX;
          default: v = IDX_MIN + 1'b1;
        endcase
      end
      2: v = (int'($urandom_range(60)) - 30) <<< $urandom_range(28);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Mostly same-array pairs with related strides and offsets, so the gcd,
  // divisibility and distance paths all get real work; the rest is noise.
  function automatic gdt_pkg::in_item_t random_access_pair();
    gdt_pkg::in_item_t               item;
    logic [gdt_pkg::INDEX_WIDTH-1:0] factor;
    logic [gdt_pkg::INDEX_WIDTH-1:0] k;
    item.first_array_id  = gdt_pkg::ARRAY_ID_WIDTH'($urandom_range(16'hFFFF));
    item.second_array_id = ($urandom_range(9) < 7) ? item.first_array_id
                         : gdt_pkg::ARRAY_ID_WIDTH'($urandom_range(16'hFFFF));
    item.first_stride = random_index();
    case ($urandom_range(3))
      0: item.second_stride = item.first_stride;
      1: item.second_stride = random_index();
      2: begin
        factor = $urandom_range(1, 64);
        item.first_stride  = factor * (int'($urandom_range(40)) - 20);
        item.second_stride = factor * (int'($urandom_range(40)) - 20);
      end
      default: item.second_stride = -item.first_stride;
    endcase
    item.first_offset = random_index();
    k = int'($urandom_range(200)) - 100;
    case ($urandom_range(4))
      0: item.second_offset = item.first_offset;
      1: item.second_offset = item.first_offset + k * item.second_stride;
      2: item.second_offset = item.first_offset + k;
      default: item.second_offset = random_index();
    endcase
    return item;
  endfunction

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_data  <= '0;
    idle_pct  = 38;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero strides, different arrays, extreme strides and offsets,
    // divisible and non-divisible differences, alternating bit patterns.
    send_transfer(make_pair(16'h0000, 16'h0000, 0, 0, 0, 0));
    send_transfer(make_pair(16'h0005, 16'h0005, 0, 0, 3, 7));
    send_transfer(make_pair(16'h0001, 16'h0002, 4, 4, 0, 8));
    send_transfer(make_pair(16'hFFFF, 16'hFFFF, 4, 6, 0, 2));
    send_transfer(make_pair(16'hFFFF, 16'hFFFF, 4, 6, 0, 3));
    send_transfer(make_pair(16'h0007, 16'h0007, IDX_MIN, IDX_MIN, 0, IDX_MIN));
    send_transfer(make_pair(16'h0007, 16'h0007, IDX_MIN, 0, 1, 0));
    send_transfer(make_pair(16'h0000, 16'h0000, 3, 3, IDX_MIN, IDX_MAX));
    send_transfer(make_pair(16'h0000, 16'h0000, 3, 3, IDX_MAX, IDX_MIN));
    send_transfer(make_pair(16'h0009, 16'h0009, IDX_MAX, IDX_MIN, 0, 1));
    send_transfer(make_pair(16'h0009, 16'h0009, -6, 9, 10, 1));
    send_transfer(make_pair(16'h0009, 16'h0009, 0, 12, 0, 24));
    send_transfer(make_pair(16'h0009, 16'h0009, -12, 0, 24, 0));
    send_transfer(make_pair(16'h0003, 16'h0003, -1, -1, -5, 5));
    send_transfer(make_pair(16'hFFFF, 16'h0000, IDX_MIN, IDX_MIN, IDX_MIN, IDX_MIN));
    send_transfer(make_pair(16'h0000, 16'hFFFF, IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX));
    send_transfer(make_pair(16'h0002, 16'h0002, 0, 0, IDX_MIN, IDX_MIN));
    send_transfer(make_pair(16'h0002, 16'h0002, 0, 0, IDX_MIN, IDX_MAX));
    send_transfer(make_pair(16'h0004, 16'h0004, 32'h4000_0000, 32'h4000_0000, 0,
                            32'hC000_0000));
    send_transfer(make_pair(16'h0004, 16'h0004, 1, 0, 123, -456));
    send_transfer(make_pair(16'hAAAA, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'hAAAA_AAAA, 32'h5555_5555));
    send_transfer(make_pair(16'h5555, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h5555_5555, 32'hAAAA_AAAA));

    // Random phases: sender idles at times, then often, then never. Now and then
    // hold off until the block has emptied out completely.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 38 : (phase == 1) ? 83 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_transfer(random_access_pair());
        if ($urandom_range(99) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end

    // Let any stray strobe show up before the verdict.
    repeat (WORST_LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gdt_pkg.sv
rtl/gdt_datapath.sv
rtl/gdt_ctrl.sv
rtl/gcd_dependence_test_unit.sv
rtl/gdt_checker.sv
tb/dependence_checker.sv
tb/gcd_dependence_test_unit_tb.sv
